@@ hw/rtl/rmp_pkg.sv @@
// ----------------------------------------------------------------------------
// rmp_pkg
// Shared types and constants for the multibulk request parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rmp_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned BULK_W   = 32;
   localparam int unsigned LINE_W   = 21;
   localparam int unsigned ACC_W    = 33;
   localparam int unsigned PROD_W   = ACC_W + 4;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DATA_W = 32;

   localparam int unsigned MAX_ARGS_DEFAULT = 1024 * 1024;

   localparam logic [ACC_W-1:0]  ACC_MAX       = {ACC_W{1'b1}};
   localparam logic [LINE_W-1:0] LINE_SAT      = {LINE_W{1'b1}};
   localparam logic [BULK_W-1:0] BULK_LEN_RST  = 32'd536870912;
   localparam logic [LINE_W-1:0] LINE_LEN_RST  = LINE_W'(1024 * 64);

   localparam logic [BYTE_W-1:0] CHAR_STAR   = 8'h2A;
   localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
   localparam logic [BYTE_W-1:0] CHAR_CR     = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_MINUS  = 8'h2D;
   localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE   = 8'h39;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_BULK_LEN = 1'b0,
      CSR_MAX_LINE_LEN = 1'b1
   } csr_idx_type;

   typedef enum logic [1:0] {
      KIND_ARG_BYTE  = 2'd0,
      KIND_ARG_END   = 2'd1,
      KIND_EMPTY_CMD = 2'd2,
      KIND_ERROR     = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE       = 3'd0,
      ERR_NOT_STAR   = 3'd1,
      ERR_BAD_COUNT  = 3'd2,
      ERR_NOT_DOLLAR = 3'd3,
      ERR_BAD_LENGTH = 3'd4,
      ERR_LINE_LONG  = 3'd5
   } err_type;

   typedef struct packed {
      logic [BULK_W-1:0] max_bulk_len;
      logic [LINE_W-1:0] max_line_len;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      kind_type          kind;
      logic [BYTE_W-1:0] arg_byte;
      logic              command_last;
      err_type           fault_code;
   } result_type;

endpackage

`default_nettype wire

@@ hw/rtl/rmp_csr.sv @@
// ----------------------------------------------------------------------------
// rmp_csr
// Configuration registers: bulk length limit and header line length limit.
// ----------------------------------------------------------------------------
`default_nettype none

module rmp_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [rmp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [rmp_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output rmp_pkg::cfg_type                      cfg
);
   import rmp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_MAX_BULK_LEN: cfg_in.max_bulk_len = csr_wdata[BULK_W-1:0];
            CSR_MAX_LINE_LEN: cfg_in.max_line_len = csr_wdata[LINE_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_bulk_len <= BULK_LEN_RST;
         cfg_ff.max_line_len <= LINE_LEN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/rmp_parser.sv @@
// ----------------------------------------------------------------------------
// rmp_parser
// Parser state and per-beat next-state/result logic.
// ----------------------------------------------------------------------------
`default_nettype none

module rmp_parser #(
   parameter int unsigned MAX_ARGS = rmp_pkg::MAX_ARGS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          fire,
   input  wire logic [rmp_pkg::BYTE_W-1:0]    in_byte,
   input  wire rmp_pkg::cfg_type              cfg,
   output rmp_pkg::result_type                result
);
   import rmp_pkg::*;

   localparam int unsigned ARGS_W = $clog2(MAX_ARGS + 1);
   localparam logic [ACC_W-1:0] MAX_ARGS_ACC = ACC_W'(MAX_ARGS);

   typedef enum logic [3:0] {
      PH_HDR_START, PH_HDR_NUM, PH_HDR_BAD, PH_HDR_LF, PH_HDR_BADLF,
      PH_BLK_START, PH_BLK_NUM, PH_BLK_BAD, PH_BLK_LF, PH_BLK_BADLF,
      PH_DATA, PH_TAIL1, PH_TAIL2, PH_ERR
   } phase_type;

   typedef struct packed {
      logic bad;
      logic lzero;
      logic digit;
      logic sign;
   } flags_type;

   phase_type          phase_ff,  phase_in;
   logic [ARGS_W-1:0]  args_ff,   args_in;
   logic [BULK_W-1:0]  bulk_ff,   bulk_in;
   logic [ACC_W-1:0]   acc_ff,    acc_in;
   flags_type          flags_ff,  flags_in;
   logic [LINE_W-1:0]  line_ff,   line_in;
   result_type         res;

   logic               hdr;
   logic               sub_start, sub_num, sub_lf, sub_badlf;
   logic [ACC_W-1:0]   acc_eff;
   flags_type          flags_eff;
   logic [LINE_W-1:0]  line_eff;
   logic [LINE_W-1:0]  line_next;
   logic               is_digit;
   logic [3:0]         digit_val;
   logic [PROD_W-1:0]  prod;
   logic               num_ok;
   logic [BULK_W-1:0]  bulk_dec;
   logic [ARGS_W-1:0]  args_dec;

   assign result = res;

   always_comb begin
      hdr       = 1'b0;
      sub_start = 1'b0;
      sub_num   = 1'b0;
      sub_lf    = 1'b0;
      sub_badlf = 1'b0;
      unique case (phase_ff)
         PH_HDR_START: begin hdr = 1'b1; sub_start = 1'b1; end
         PH_HDR_NUM:   begin hdr = 1'b1; sub_num   = 1'b1; end
         PH_HDR_BAD:   begin hdr = 1'b1; end
         PH_HDR_LF:    begin hdr = 1'b1; sub_lf    = 1'b1; end
         PH_HDR_BADLF: begin hdr = 1'b1; sub_badlf = 1'b1; end
         PH_BLK_START: begin sub_start = 1'b1; end
         PH_BLK_NUM:   begin sub_num   = 1'b1; end
         PH_BLK_LF:    begin sub_lf    = 1'b1; end
         PH_BLK_BADLF: begin sub_badlf = 1'b1; end
         default:      begin hdr = 1'b0; end
      endcase
   end

   always_comb begin
      acc_eff   = sub_start ? '0 : acc_ff;
      flags_eff = sub_start ? '0 : flags_ff;
      line_eff  = sub_start ? '0 : line_ff;
      line_next = (line_eff < LINE_SAT) ? line_eff + LINE_W'(1) : line_eff;
      is_digit  = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
      digit_val = 4'(in_byte - CHAR_ZERO);
      prod      = {acc_eff, 3'b000} + {2'b00, acc_eff, 1'b0} + PROD_W'(digit_val);
      num_ok    = flags_ff.digit && !flags_ff.bad && !(flags_ff.sign && flags_ff.lzero);
      bulk_dec  = (bulk_ff != '0) ? bulk_ff - BULK_W'(1) : bulk_ff;
      args_dec  = (args_ff != '0) ? args_ff - ARGS_W'(1) : args_ff;
   end

   always_comb begin
      phase_in = phase_ff;
      args_in  = args_ff;
      bulk_in  = bulk_ff;
      acc_in   = acc_ff;
      flags_in = flags_ff;
      line_in  = line_ff;
      res      = '{valid: 1'b0, kind: KIND_ARG_BYTE, arg_byte: '0,
                   command_last: 1'b0, fault_code: ERR_NONE};

      if (sub_badlf) begin
         phase_in       = PH_ERR;
         res.valid      = 1'b1;
         res.kind       = KIND_ERROR;
         res.fault_code = hdr ? ERR_NOT_STAR : ERR_NOT_DOLLAR;
      end else if (sub_lf) begin
         acc_in   = '0;
         flags_in = '0;
         if (hdr) begin
            if (!num_ok) begin
               phase_in       = PH_ERR;
               res.valid      = 1'b1;
               res.kind       = KIND_ERROR;
               res.fault_code = ERR_BAD_COUNT;
            end else if (flags_ff.sign || acc_ff == '0) begin
               phase_in  = PH_HDR_START;
               res.valid = 1'b1;
               res.kind  = KIND_EMPTY_CMD;
            end else if (acc_ff > MAX_ARGS_ACC) begin
               phase_in       = PH_ERR;
               res.valid      = 1'b1;
               res.kind       = KIND_ERROR;
               res.fault_code = ERR_BAD_COUNT;
            end else begin
               args_in  = acc_ff[ARGS_W-1:0];
               phase_in = PH_BLK_START;
            end
         end else begin
            if (!num_ok || flags_ff.sign || acc_ff > {1'b0, cfg.max_bulk_len}) begin
               phase_in       = PH_ERR;
               res.valid      = 1'b1;
               res.kind       = KIND_ERROR;
               res.fault_code = ERR_BAD_LENGTH;
            end else begin
               bulk_in  = acc_ff[BULK_W-1:0];
               phase_in = (acc_ff != '0) ? PH_DATA : PH_TAIL1;
            end
         end
      end else if (phase_ff < PH_DATA) begin
         acc_in   = acc_eff;
         flags_in = flags_eff;
         line_in  = line_eff;
         if (in_byte == CHAR_CR) begin
            if (sub_num) begin
               phase_in = hdr ? PH_HDR_LF : PH_BLK_LF;
            end else begin
               phase_in = hdr ? PH_HDR_BADLF : PH_BLK_BADLF;
            end
         end else begin
            line_in = line_next;
            if (line_next > cfg.max_line_len) begin
               phase_in       = PH_ERR;
               res.valid      = 1'b1;
               res.kind       = KIND_ERROR;
               res.fault_code = ERR_LINE_LONG;
            end else if (sub_start) begin
               if (in_byte == (hdr ? CHAR_STAR : CHAR_DOLLAR)) begin
                  phase_in = hdr ? PH_HDR_NUM : PH_BLK_NUM;
               end else begin
                  phase_in = hdr ? PH_HDR_BAD : PH_BLK_BAD;
               end
            end else if (sub_num) begin
               if (is_digit) begin
                  if (flags_eff.lzero) flags_in.bad = 1'b1;
                  if (!flags_eff.digit && digit_val == 4'd0) flags_in.lzero = 1'b1;
                  flags_in.digit = 1'b1;
                  if (prod > PROD_W'(ACC_MAX)) begin
                     acc_in       = ACC_MAX;
                     flags_in.bad = 1'b1;
                  end else begin
                     acc_in = prod[ACC_W-1:0];
                  end
               end else if (in_byte == CHAR_MINUS && flags_eff == '0) begin
                  flags_in      = '0;
                  flags_in.sign = 1'b1;
               end else begin
                  flags_in.bad = 1'b1;
               end
            end
         end
      end else begin
         unique case (phase_ff)
            PH_DATA: begin
               bulk_in = bulk_dec;
               if (bulk_dec == '0) phase_in = PH_TAIL1;
               res.valid    = 1'b1;
               res.kind     = KIND_ARG_BYTE;
               res.arg_byte = in_byte;
            end
            PH_TAIL1: begin
               phase_in = PH_TAIL2;
            end
            PH_TAIL2: begin
               args_in          = args_dec;
               phase_in         = (args_dec == '0) ? PH_HDR_START : PH_BLK_START;
               res.valid        = 1'b1;
               res.kind         = KIND_ARG_END;
               res.command_last = (args_dec == '0);
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR_START;
         args_ff  <= '0;
         bulk_ff  <= '0;
         acc_ff   <= '0;
         flags_ff <= '0;
         line_ff  <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         args_ff  <= args_in;
         bulk_ff  <= bulk_in;
         acc_ff   <= acc_in;
         flags_ff <= flags_in;
         line_ff  <= line_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/resp_multibulk_request_parser.sv @@
// ----------------------------------------------------------------------------
// resp_multibulk_request_parser
// Byte-serial multibulk request parser.
//
// Request bytes enter on req_ (valid/stall), one per beat. Each beat yields
// zero or one result beat on rsp_: an argument byte, an argument end (with
// command_last on the final argument), an empty-command mark, or a protocol
// error, after which the block stays silent until reset.
// A byte is captured in an input register, parsed against the state once the
// output register can take its result, and its result lands in the output
// register, from which it is offered on rsp_. Throughput is one byte per cycle
// while rsp_stall is low, set by the state update made for each byte.
// The input register still takes a byte while a result waits in the output
// register; when the receiver stalls with both registers full, req_stall
// rises and the pipeline holds.
// Synchronous reset returns the parser to the count header, empties both
// registers and restores the default limits. The csr_ port is always ready
// and should be written only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module resp_multibulk_request_parser #(
   parameter int unsigned MAX_ARGS = rmp_pkg::MAX_ARGS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [7:0]                       req_in_byte,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [1:0]                            rsp_kind,
   output logic [7:0]                            rsp_arg_byte,
   output logic                                  rsp_command_last,
   output logic [2:0]                            rsp_fault_code,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [rmp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [rmp_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rmp_pkg::*;

   cfg_type           cfg;
   result_type        res;
   logic              fire;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff,  in_byte_in;
   result_type        out_ff,      out_in;

   rmp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rmp_parser #(
      .MAX_ARGS (MAX_ARGS)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .in_byte (in_byte_ff),
      .cfg     (cfg),
      .result  (res)
   );

   assign fire      = in_valid_ff && (!out_ff.valid || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;

   assign rsp_valid        = out_ff.valid;
   assign rsp_kind         = out_ff.kind;
   assign rsp_arg_byte     = out_ff.arg_byte;
   assign rsp_command_last = out_ff.command_last;
   assign rsp_fault_code   = out_ff.fault_code;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_in_byte;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end

      out_in = out_ff;
      if (fire) begin
         out_in = res;
      end else if (out_ff.valid && !rsp_stall) begin
         out_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_ff.valid <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_ff.valid <= out_in.valid;
      end
      in_byte_ff          <= in_byte_in;
      out_ff.kind         <= out_in.kind;
      out_ff.arg_byte     <= out_in.arg_byte;
      out_ff.command_last <= out_in.command_last;
      out_ff.fault_code   <= out_in.fault_code;
   end

endmodule

`default_nettype wire
